FILE: design/label_adjacency_scanner_assert.svh
// ----------------------------------------------------------------------------
// Label adjacency scanner assertion macros
// Concurrent assertion wrappers used by las_store. Simulation gets
// the full properties; synthesis sees empty macros.
// ----------------------------------------------------------------------------
`ifndef LABEL_ADJACENCY_SCANNER_ASSERT_SVH
`define LABEL_ADJACENCY_SCANNER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds in that cycle.
`define LAS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("label adjacency scanner: assertion failed");

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define LAS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("label adjacency scanner: assertion failed");

`else

`define LAS_ASSERT_IMP(name, clk, rst, ante, cons)
`define LAS_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: design/las_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// las_pkg
// Types and constants shared by the label adjacency scanner modules.
// ----------------------------------------------------------------------------
package las_pkg;

   // Table geometry.
   localparam int LABEL_W        = 10;
   localparam int LABEL_COUNT    = 1024;
   localparam int ADDR_W         = $clog2(LABEL_COUNT);
   localparam int NEIGHBOR_SLOTS = 4;
   localparam int COLOR_W        = 8;
   localparam int GAP_W          = 8;

   // Scan constants.
   localparam logic [GAP_W-1:0]   GAP_MAX       = 8'd255;
   localparam logic [COLOR_W-1:0] COLOR_UNKNOWN = 8'd127;
   localparam logic [GAP_W-1:0]   DIST_RESET    = 8'd10;

   // Operation codes of an input beat.
   localparam logic [1:0] OP_PIXEL = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Register file.
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_DISTANCE = 2'd0;

   // Input beat.
   typedef struct packed {
      logic [1:0]         operation;
      logic               line_start;
      logic [COLOR_W-1:0] color;
      logic [LABEL_W-1:0] label;
      logic [LABEL_W-1:0] entry_index;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic               linked;
      logic [LABEL_W-1:0] first_label;
      logic [LABEL_W-1:0] second_label;
      logic [LABEL_W-1:0] neighbor_0;
      logic [LABEL_W-1:0] neighbor_1;
      logic [LABEL_W-1:0] neighbor_2;
      logic [LABEL_W-1:0] neighbor_3;
      logic               entry_invalid;
   } rsp_type;

   // One neighbor table entry.
   typedef struct packed {
      logic                                  bad;
      logic [NEIGHBOR_SLOTS-1:0][LABEL_W-1:0] slot;
   } entry_type;

   // What the table engine does for one item.
   typedef enum logic [1:0] {
      TK_NONE  = 2'd0,
      TK_LINK  = 2'd1,
      TK_READ  = 2'd2,
      TK_CLEAR = 2'd3
   } table_kind_type;

   // Job handed from the scan front end to the table engine.
   typedef struct packed {
      table_kind_type     kind;
      logic [LABEL_W-1:0] first_label;
      logic [LABEL_W-1:0] second_label;
      logic [ADDR_W-1:0]  index;
   } table_job_type;

   // One memory operation in flight.
   typedef struct packed {
      table_kind_type     kind;
      logic [ADDR_W-1:0]  addr;
      logic [LABEL_W-1:0] other;
      logic               last;
   } mem_op_type;

endpackage

FILE: design/las_store.sv
`timescale 1ns / 1ps
`include "label_adjacency_scanner_assert.svh"
// ----------------------------------------------------------------------------
// las_store
// Neighbor table engine: one synchronous memory with a read-modify-write
// pipeline (issue, modify/write), one-deep write forwarding, a clearing sweep
// after reset and the result output register.
// ----------------------------------------------------------------------------
module las_store import las_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          job_valid,
   input  table_job_type job,
   output logic          job_ready,
   output logic          rsp_valid,
   output rsp_type       rsp_data,
   input  logic          rsp_stall
);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LABEL_COUNT - 1);

   // Clearing sweep.
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   // Issue stage.
   logic          i_valid_ff, i_valid_in;
   logic          i_phase_ff, i_phase_in;
   table_job_type i_job_ff;

   // Modify stage.
   logic       m_valid_ff, m_valid_in;
   mem_op_type m_op_ff;

   // Memory and forwarding.
   entry_type entry_mem_ff [LABEL_COUNT];
   entry_type rdata_ff;
   logic      fwd_hit_ff;
   entry_type fwd_data_ff;

   // Output register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;

   logic       out_ready, m_leave, m_free, m_out_fire, m_we;
   logic       issue_last, issue_fire, i_free, job_fire;
   mem_op_type issue_op;
   entry_type  cur_entry, updated_entry, m_wdata, wdata;
   logic       we;
   logic [ADDR_W-1:0] waddr;
   rsp_type    m_rsp;

   // Enter a label into an entry: skip if present, else first empty slot,
   // else mark the entry as overflowed.
   function automatic entry_type add_neighbor(entry_type e, logic [LABEL_W-1:0] other);
      entry_type r;
      logic      done;
      r    = e;
      done = 1'b0;
      for (int k = 0; k < NEIGHBOR_SLOTS; k++) begin
         if (!done) begin
            if (e.slot[k] == other) begin
               done = 1'b1;
            end else if (e.slot[k] == '0) begin
               r.slot[k] = other;
               done      = 1'b1;
            end
         end
      end
      if (!done) begin
         r.bad = 1'b1;
      end
      return r;
   endfunction

   // Pipeline flow control.
   always_comb begin
      out_ready  = !rsp_valid_ff || !rsp_stall;
      m_leave    = m_valid_ff && (!m_op_ff.last || out_ready);
      m_free     = !m_valid_ff || m_leave;
      issue_last = (i_job_ff.kind != TK_LINK) || i_phase_ff;
      issue_fire = i_valid_ff && m_free;
      i_free     = !i_valid_ff || (issue_fire && issue_last);
      job_ready  = i_free && !clearing_ff;
      job_fire   = job_valid && job_ready;
   end

   // A link becomes two updates: the earlier label's entry, then the current one.
   always_comb begin
      issue_op.kind  = i_job_ff.kind;
      issue_op.last  = issue_last;
      issue_op.addr  = '0;
      issue_op.other = '0;
      case (i_job_ff.kind)
         TK_LINK: begin
            if (i_phase_ff) begin
               issue_op.addr  = ADDR_W'(i_job_ff.second_label);
               issue_op.other = i_job_ff.first_label;
            end else begin
               issue_op.addr  = ADDR_W'(i_job_ff.first_label);
               issue_op.other = i_job_ff.second_label;
            end
         end
         TK_READ, TK_CLEAR: begin
            issue_op.addr = i_job_ff.index;
         end
         default: begin
            issue_op.addr = '0;
         end
      endcase
   end

   // Modify stage: forwarded or memory data, update and write-back value.
   always_comb begin
      cur_entry     = fwd_hit_ff ? fwd_data_ff : rdata_ff;
      updated_entry = add_neighbor(cur_entry, m_op_ff.other);
      m_we          = m_leave && ((m_op_ff.kind == TK_LINK) || (m_op_ff.kind == TK_CLEAR));
      m_wdata       = (m_op_ff.kind == TK_CLEAR) ? entry_type'('0) : updated_entry;
      m_out_fire    = m_leave && m_op_ff.last;
   end

   // Memory write port is shared by the sweep and the modify stage.
   always_comb begin
      we    = clearing_ff || m_we;
      waddr = clearing_ff ? clear_addr_ff : m_op_ff.addr;
      wdata = clearing_ff ? entry_type'('0) : m_wdata;
   end

   // Result beat built from the last operation of an item.
   always_comb begin
      m_rsp = '0;
      case (m_op_ff.kind)
         TK_LINK: begin
            m_rsp.linked       = 1'b1;
            m_rsp.first_label  = m_op_ff.other;
            m_rsp.second_label = LABEL_W'(m_op_ff.addr);
         end
         TK_READ: begin
            m_rsp.neighbor_0    = cur_entry.slot[0];
            m_rsp.neighbor_1    = cur_entry.slot[1];
            m_rsp.neighbor_2    = cur_entry.slot[2];
            m_rsp.neighbor_3    = cur_entry.slot[3];
            m_rsp.entry_invalid = cur_entry.bad;
         end
         default: begin
            m_rsp = '0;
         end
      endcase
   end

   // Next state of the control registers.
   always_comb begin
      clearing_in   = clearing_ff && (clear_addr_ff != LAST_ADDR);
      clear_addr_in = clearing_ff ? clear_addr_ff + 1'b1 : clear_addr_ff;
      i_valid_in    = job_fire || (i_valid_ff && !(issue_fire && issue_last));
      i_phase_in    = job_fire ? 1'b0 : (issue_fire ? 1'b1 : i_phase_ff);
      m_valid_in    = issue_fire || (m_valid_ff && !m_leave);
      rsp_valid_in  = m_out_fire || (rsp_valid_ff && rsp_stall);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         i_valid_ff    <= 1'b0;
         i_phase_ff    <= 1'b0;
         m_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         i_valid_ff    <= i_valid_in;
         i_phase_ff    <= i_phase_in;
         m_valid_ff    <= m_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (job_fire) begin
         i_job_ff <= job;
      end
      if (issue_fire) begin
         m_op_ff     <= issue_op;
         fwd_hit_ff  <= m_we && (m_op_ff.addr == issue_op.addr);
         fwd_data_ff <= m_wdata;
      end
      if (m_out_fire) begin
         rsp_ff <= m_rsp;
      end
   end

   // Neighbor table memory: one write and one registered read a cycle.
   always_ff @(posedge clock) begin
      if (we) begin
         entry_mem_ff[waddr] <= wdata;
      end
      if (issue_fire) begin
         rdata_ff <= entry_mem_ff[issue_op.addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Nothing moves through the pipeline while the sweep runs.
   `LAS_ASSERT_IMP(a_sweep_idle, clock, reset, clearing_ff, !i_valid_ff && !m_valid_ff)
   // The sweep ends only after it has wrapped through every entry.
   `LAS_ASSERT_IMP(a_sweep_full, clock, reset, $fell(clearing_ff), clear_addr_ff == '0)
   // The second update of a link follows the first directly.
   `LAS_ASSERT_NXT(a_link_pair, clock, reset,
      m_valid_ff && (m_op_ff.kind == TK_LINK) && !m_op_ff.last,
      m_valid_ff && (m_op_ff.kind == TK_LINK) && m_op_ff.last)
   // A reported link joins two different foreground labels.
   `LAS_ASSERT_IMP(a_link_labels, clock, reset, rsp_valid_ff && rsp_ff.linked,
      (rsp_ff.first_label != rsp_ff.second_label) && (rsp_ff.first_label != '0))

endmodule

FILE: design/label_adjacency_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_adjacency_scanner
// Scans labelled pixels, links neighboring components of different color in
// a four-slot neighbor table, and serves table reads and clears.
//
//   Channel | Ports   | Direction | Beat
//   --------+---------+-----------+------------------------------------------
//   request | req_*   | in        | pixel, table read or table clear
//   result  | rsp_*   | out       | link report, table entry or all-zero beat, one per item
//   config  | csr_*   | in/out    | APB register access (max_distance)
//
// A pixel without a link, a read and a clear each issue one memory operation;
// a linking pixel issues two, since it updates two entries through the
// single memory write port. A request beat passes the issue register, the
// modify stage and the output register; new requests enter behind it.
// After reset a sweep clears the 1024-entry table; req_stall stays high
// meanwhile, and register writes are taken as usual.
// A stalled result holds the output register; up to two more items are taken
// into the pipeline before req_stall rises.
// ----------------------------------------------------------------------------
module label_adjacency_scanner import las_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel.
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [GAP_W-1:0]   max_dist_ff, max_dist_in;
   logic [COLOR_W-1:0] prev_color_ff, prev_color_in;
   logic [LABEL_W-1:0] prev_label_ff, prev_label_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;

   logic               csr_write;
   logic               job_ready, req_fire, is_pixel, link;
   logic [COLOR_W-1:0] eff_color;
   logic [LABEL_W-1:0] eff_label;
   logic [GAP_W-1:0]   eff_gap;
   table_job_type      job;

   // Register access.
   always_comb begin
      csr_pready  = 1'b1;
      csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
      max_dist_in = max_dist_ff;
      if (csr_write && (csr_paddr == REG_MAX_DISTANCE)) begin
         max_dist_in = csr_pwdata[GAP_W-1:0];
      end
      csr_prdata = (csr_paddr == REG_MAX_DISTANCE) ? CSR_DATA_W'(max_dist_ff) : '0;
   end

   // Running scan state as seen by this pixel, after a line start.
   always_comb begin
      req_stall = !job_ready;
      req_fire  = req_valid && !req_stall;
      is_pixel  = (req_data.operation == OP_PIXEL);
      eff_color = req_data.line_start ? COLOR_UNKNOWN : prev_color_ff;
      eff_label = req_data.line_start ? '0 : prev_label_ff;
      eff_gap   = req_data.line_start ? '0 : gap_ff;
      link      = (req_data.label != '0) && (req_data.label != eff_label) &&
                  (eff_label != '0) && (eff_color != req_data.color) &&
                  (eff_gap <= max_dist_ff);
   end

   // Scan state update for a pixel beat.
   always_comb begin
      prev_color_in = prev_color_ff;
      prev_label_in = prev_label_ff;
      gap_in        = gap_ff;
      if (req_fire && is_pixel) begin
         prev_color_in = eff_color;
         prev_label_in = eff_label;
         if (req_data.label == '0) begin
            gap_in = (eff_gap < GAP_MAX) ? eff_gap + 1'b1 : eff_gap;
         end else begin
            gap_in = GAP_W'(1);
            if (req_data.label != eff_label) begin
               prev_color_in = req_data.color;
               prev_label_in = req_data.label;
            end
         end
      end
   end

   // Job for the table engine.
   always_comb begin
      job.first_label  = eff_label;
      job.second_label = req_data.label;
      job.index        = ADDR_W'(req_data.entry_index);
      case (req_data.operation)
         OP_PIXEL: job.kind = link ? TK_LINK : TK_NONE;
         OP_READ:  job.kind = TK_READ;
         OP_CLEAR: job.kind = TK_CLEAR;
         default:  job.kind = TK_NONE;
      endcase
   end

   // Scan and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff   <= DIST_RESET;
         prev_color_ff <= COLOR_UNKNOWN;
         prev_label_ff <= '0;
         gap_ff        <= '0;
      end else begin
         max_dist_ff   <= max_dist_in;
         prev_color_ff <= prev_color_in;
         prev_label_ff <= prev_label_in;
         gap_ff        <= gap_in;
      end
   end

   // Neighbor table engine and output register.
   las_store u_store (
      .clock     (clock),
      .reset     (reset),
      .job_valid (req_valid),
      .job       (job),
      .job_ready (job_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule
